/* sv/lce_pkg.sv */
// Shared types, constants and helpers of the current-synapse LIF neuron update block.
package lce_pkg;

   localparam int NEURONS = 1024;
   localparam int IDX_W = 10;
   localparam int DEPTH = 2 ** IDX_W;
   localparam int CNT_W = IDX_W + 1;
   localparam int DATA_W = 32;
   localparam int TICKS_W = 16;
   localparam int HIST_W = 64;
   localparam int SAT_W = 48;
   localparam int RND_HALF = 32768;
   localparam int FRAC_W = 16;

   localparam int SYN_PROD_W = 50;
   localparam int LEAK_DIFF_W = 33;
   localparam int LEAK_PROD_W = 51;
   localparam int LEAK_Q_W = LEAK_PROD_W - FRAC_W;
   localparam int DRIVE_PROD_W = 64;

   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 112;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_EXC_DECAY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INH_DECAY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_CAP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_TAU = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REST_V = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_V = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH_V = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRACT = 3'd7;

   localparam logic [TICKS_W-1:0] TICKS_MAX = 16'hFFFF;
   localparam logic [TICKS_W-1:0] TICKS_ONE = 16'd1;

   localparam logic signed [SAT_W-1:0] SAT_HI = 48'sh0000_7FFF_FFFF;
   localparam logic signed [SAT_W-1:0] SAT_LO = 48'shFFFF_8000_0000;

   typedef struct packed {
      logic [16:0]              exc_decay;
      logic [16:0]              inh_decay;
      logic [30:0]              inv_capacitance;
      logic [16:0]              inv_membrane_tau;
      logic signed [DATA_W-1:0] rest_voltage;
      logic signed [DATA_W-1:0] reset_voltage;
      logic signed [DATA_W-1:0] threshold_voltage;
      logic [TICKS_W-1:0]       refractory_ticks;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      exc_decay:         17'd52429,
      inh_decay:         17'd52429,
      inv_capacitance:   31'd65536,
      inv_membrane_tau:  17'd3277,
      rest_voltage:      32'sd0,
      reset_voltage:     32'sd0,
      threshold_voltage: 32'sd65536,
      refractory_ticks:  16'd2
   };

   typedef struct packed {
      logic signed [DATA_W-1:0] voltage;
      logic signed [DATA_W-1:0] exc;
      logic signed [DATA_W-1:0] inh;
      logic [TICKS_W-1:0]       ticks;
      logic [HIST_W-1:0]        history;
   } state_type;

   localparam state_type STATE_RESET = '{
      voltage: '0,
      exc:     '0,
      inh:     '0,
      ticks:   TICKS_MAX,
      history: '0
   };

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
   } stage_en_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
      logic signed [DATA_W-1:0] r;
      if (x > SAT_HI) begin
         r = SAT_HI[DATA_W-1:0];
      end else if (x < SAT_LO) begin
         r = SAT_LO[DATA_W-1:0];
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

/* sv/lce_csr.sv */
// Configuration register bank shared by all neurons.
module lce_csr import lce_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_EXC_DECAY: cfg_in.exc_decay = csr_wdata[16:0];
            CSR_INH_DECAY: cfg_in.inh_decay = csr_wdata[16:0];
            CSR_INV_CAP:   cfg_in.inv_capacitance = csr_wdata[30:0];
            CSR_INV_TAU:   cfg_in.inv_membrane_tau = csr_wdata[16:0];
            CSR_REST_V:    cfg_in.rest_voltage = $signed(csr_wdata);
            CSR_RESET_V:   cfg_in.reset_voltage = $signed(csr_wdata);
            CSR_THRESH_V:  cfg_in.threshold_voltage = $signed(csr_wdata);
            CSR_REFRACT:   cfg_in.refractory_ticks = csr_wdata[TICKS_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* sv/lce_state_ram.sv */
// Per-neuron state memory with registered read and a clearing sweep after reset.
module lce_state_ram import lce_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output state_type        rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  state_type        wr_data,
   output logic             clearing
);

   state_type mem [DEPTH];
   state_type rd_data_ff;
   logic [CNT_W-1:0] clr_cnt_ff, clr_cnt_in;

   assign clearing = !clr_cnt_ff[CNT_W-1];
   assign clr_cnt_in = clearing ? clr_cnt_ff + CNT_W'(1) : clr_cnt_ff;
   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing) begin
         mem[clr_cnt_ff[IDX_W-1:0]] <= STATE_RESET;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rd_en && !wr_en)
      else $error("State memory accessed during the clearing sweep.");

   assert property (@(posedge clock) disable iff (reset)
      wr_en && rd_en |-> rd_addr != wr_addr)
      else $error("Read of a neuron whose update is still being written back.");

endmodule

/* sv/lce_syn.sv */
// Synaptic current pipeline: decay, input add and total current.
module lce_syn import lce_pkg::*; (
   input  logic                     clock,
   input  cfg_type                  cfg,
   input  stage_en_type             en,
   input  logic signed [DATA_W-1:0] exc_old,
   input  logic signed [DATA_W-1:0] inh_old,
   input  logic signed [DATA_W-1:0] exc_in,
   input  logic signed [DATA_W-1:0] inh_in,
   input  logic signed [DATA_W-1:0] ext_in,
   input  logic signed [DATA_W-1:0] off_in,
   output logic signed [DATA_W-1:0] itot,
   output logic signed [DATA_W-1:0] exc_new,
   output logic signed [DATA_W-1:0] inh_new
);

   logic signed [SYN_PROD_W-1:0] exc_prod_ff, inh_prod_ff, exc_prod_in, inh_prod_in;
   logic signed [DATA_W-1:0] exc_in2_ff, inh_in2_ff, ext2_ff, off2_ff;
   logic signed [DATA_W-1:0] exc3_ff, inh3_ff, ext3_ff, off3_ff, exc3_in, inh3_in;
   logic signed [DATA_W-1:0] itot4_ff, itot4_in, exc4_ff, inh4_ff;
   logic signed [DATA_W-1:0] exc5_ff, inh5_ff, exc6_ff, inh6_ff;
   logic [SYN_PROD_W-1:0] exc_rnd, inh_rnd;
   logic signed [SAT_W-1:0] exc_sum, inh_sum, tot_sum;

   assign exc_prod_in = $signed({1'b0, cfg.exc_decay}) * exc_old;
   assign inh_prod_in = $signed({1'b0, cfg.inh_decay}) * inh_old;

   assign exc_rnd = exc_prod_ff + SYN_PROD_W'(RND_HALF);
   assign inh_rnd = inh_prod_ff + SYN_PROD_W'(RND_HALF);
   assign exc_sum = SAT_W'($signed(exc_rnd[SYN_PROD_W-1:FRAC_W])) + SAT_W'(exc_in2_ff);
   assign inh_sum = SAT_W'($signed(inh_rnd[SYN_PROD_W-1:FRAC_W])) + SAT_W'(inh_in2_ff);
   assign exc3_in = sat32(exc_sum);
   assign inh3_in = sat32(inh_sum);

   assign tot_sum = SAT_W'(exc3_ff) + SAT_W'(inh3_ff) + SAT_W'(ext3_ff) + SAT_W'(off3_ff);
   assign itot4_in = sat32(tot_sum);

   always_ff @(posedge clock) begin
      if (en.s2) begin
         exc_prod_ff <= exc_prod_in;
         inh_prod_ff <= inh_prod_in;
         exc_in2_ff <= exc_in;
         inh_in2_ff <= inh_in;
         ext2_ff <= ext_in;
         off2_ff <= off_in;
      end
      if (en.s3) begin
         exc3_ff <= exc3_in;
         inh3_ff <= inh3_in;
         ext3_ff <= ext2_ff;
         off3_ff <= off2_ff;
      end
      if (en.s4) begin
         itot4_ff <= itot4_in;
         exc4_ff <= exc3_ff;
         inh4_ff <= inh3_ff;
      end
      if (en.s5) begin
         exc5_ff <= exc4_ff;
         inh5_ff <= inh4_ff;
      end
      if (en.s6) begin
         exc6_ff <= exc5_ff;
         inh6_ff <= inh5_ff;
      end
   end

   assign itot = itot4_ff;
   assign exc_new = exc6_ff;
   assign inh_new = inh6_ff;

endmodule

/* sv/lce_soma.sv */
// Membrane pipeline: leak, current drive, refractory hold, firing and history.
module lce_soma import lce_pkg::*; (
   input  logic                     clock,
   input  cfg_type                  cfg,
   input  stage_en_type             en,
   input  logic signed [DATA_W-1:0] v_old,
   input  logic [TICKS_W-1:0]       ticks_old,
   input  logic [HIST_W-1:0]        hist_old,
   input  logic                     force_fire,
   input  logic signed [DATA_W-1:0] itot,
   output logic                     fired,
   output logic signed [DATA_W-1:0] v_store,
   output logic [TICKS_W-1:0]       ticks_new,
   output logic [HIST_W-1:0]        hist_new
);

   logic signed [LEAK_DIFF_W-1:0] diff2_ff, diff_in;
   logic signed [LEAK_PROD_W-1:0] leak_prod3_ff, leak_prod_in;
   logic [LEAK_PROD_W-1:0] leak_rnd;
   logic signed [LEAK_Q_W-1:0] leak_q4_ff, leak_q5_ff;
   logic signed [DRIVE_PROD_W-1:0] drive_prod5_ff, drive_prod_in;
   logic [DRIVE_PROD_W-1:0] drive_rnd;
   logic signed [SAT_W-1:0] v_sum;
   logic signed [DATA_W-1:0] v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v6_in;
   logic [TICKS_W-1:0] ticks2_ff, ticks3_ff, ticks4_ff, ticks5_ff, ticks6_ff;
   logic [HIST_W-1:0] hist2_ff, hist3_ff, hist4_ff, hist5_ff, hist6_ff;
   logic refr2_ff, refr3_ff, refr4_ff, refr5_ff, refr6_ff, refr_in;
   logic force2_ff, force3_ff, force4_ff, force5_ff, force6_ff;

   assign diff_in = LEAK_DIFF_W'($signed(cfg.rest_voltage)) - LEAK_DIFF_W'(v_old);
   assign refr_in = ticks_old <= cfg.refractory_ticks;
   assign leak_prod_in = diff2_ff * $signed({1'b0, cfg.inv_membrane_tau});
   assign leak_rnd = leak_prod3_ff + LEAK_PROD_W'(RND_HALF);
   assign drive_prod_in = itot * $signed({1'b0, cfg.inv_capacitance});
   assign drive_rnd = drive_prod5_ff + DRIVE_PROD_W'(RND_HALF);
   assign v_sum = SAT_W'(v5_ff) + $signed(drive_rnd[DRIVE_PROD_W-1:FRAC_W])
                  + SAT_W'(leak_q5_ff);
   assign v6_in = refr5_ff ? v5_ff : sat32(v_sum);

   always_ff @(posedge clock) begin
      if (en.s2) begin
         diff2_ff <= diff_in;
         v2_ff <= v_old;
         ticks2_ff <= ticks_old;
         hist2_ff <= hist_old;
         refr2_ff <= refr_in;
         force2_ff <= force_fire;
      end
      if (en.s3) begin
         leak_prod3_ff <= leak_prod_in;
         v3_ff <= v2_ff;
         ticks3_ff <= ticks2_ff;
         hist3_ff <= hist2_ff;
         refr3_ff <= refr2_ff;
         force3_ff <= force2_ff;
      end
      if (en.s4) begin
         leak_q4_ff <= $signed(leak_rnd[LEAK_PROD_W-1:FRAC_W]);
         v4_ff <= v3_ff;
         ticks4_ff <= ticks3_ff;
         hist4_ff <= hist3_ff;
         refr4_ff <= refr3_ff;
         force4_ff <= force3_ff;
      end
      if (en.s5) begin
         drive_prod5_ff <= drive_prod_in;
         leak_q5_ff <= leak_q4_ff;
         v5_ff <= v4_ff;
         ticks5_ff <= ticks4_ff;
         hist5_ff <= hist4_ff;
         refr5_ff <= refr4_ff;
         force5_ff <= force4_ff;
      end
      if (en.s6) begin
         v6_ff <= v6_in;
         ticks6_ff <= ticks5_ff;
         hist6_ff <= hist5_ff;
         refr6_ff <= refr5_ff;
         force6_ff <= force5_ff;
      end
   end

   always_comb begin
      fired = (!refr6_ff && (v6_ff > $signed(cfg.threshold_voltage))) || force6_ff;
      hist_new = {hist6_ff[HIST_W-2:0], fired};
      v_store = fired ? $signed(cfg.reset_voltage) : v6_ff;
      if (fired) begin
         ticks_new = TICKS_ONE;
      end else if (ticks6_ff == TICKS_MAX) begin
         ticks_new = TICKS_MAX;
      end else begin
         ticks_new = ticks6_ff + TICKS_ONE;
      end
   end

endmodule

/* sv/lif_current_exp_neuron_update.sv */
// Top level of the LIF neuron update with exponential current synapses.
//
//   Port group  Dir  Handshake                 Payload
//   req_        in   req_tvalid / req_tready   index, exc/inh/ext/offset currents; force
//   rsp_        out  rsp_tvalid / rsp_tready   index, spike history, voltage; fired flag
//   csr_        in   csr_valid / csr_ready     register index, write data
//
// One transfer per cycle while the output is not stalled and the requested neuron is
// not in the six compute stages. An item whose neuron is still in those compute
// stages waits until that update is written back to the state memory.
// After reset a clearing sweep over every entry of the state memory runs with
// req_tready low; the configuration port is always ready. A stalled output holds the
// filled stages ahead of the first empty one in place; the stages behind it still advance.
module lif_current_exp_neuron_update import lce_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // neuron_index, exc_current, inh_current, ext_current, offset_current, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // force_fire
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_index, spike_history, new_voltage, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // fired
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DATA_W-1:0]     csr_wdata
);

   cfg_type cfg;
   stage_en_type en;
   state_type rd_state, wr_state;

   logic [7:1] cap;
   logic [6:1] valid_ff, valid_in, in_range_ff;
   logic [IDX_W-1:0] idx_ff [1:6];
   logic [IDX_W-1:0] req_idx;
   logic accept, hazard, clearing, wb_en, req_in_range;

   logic signed [DATA_W-1:0] exc1_ff, inh1_ff, ext1_ff, off1_ff;
   logic force1_ff;
   logic signed [DATA_W-1:0] itot, exc_new, inh_new, v_store;
   logic [TICKS_W-1:0] ticks_new;
   logic [HIST_W-1:0] hist_new;
   logic fired;

   logic rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_idx_ff;
   logic rsp_fired_ff;
   logic [HIST_W-1:0] rsp_hist_ff;
   logic signed [DATA_W-1:0] rsp_volt_ff;

   assign req_idx = req_tdata[IDX_W-1:0];
   assign req_in_range = 32'(req_idx) < 32'(NEURONS);

   always_comb begin
      cap[7] = !rsp_valid_ff || rsp_tready;
      for (int k = 6; k >= 1; k--) begin
         cap[k] = !valid_ff[k] || cap[k+1];
      end
   end

   always_comb begin
      hazard = 1'b0;
      for (int k = 1; k <= 6; k++) begin
         if (valid_ff[k] && (idx_ff[k] == req_idx)) begin
            hazard = 1'b1;
         end
      end
   end

   assign req_tready = cap[1] && !clearing && !hazard;
   assign accept = req_tvalid && req_tready;
   assign wb_en = valid_ff[6] && cap[7] && in_range_ff[6];

   assign en.s1 = accept;
   assign en.s2 = cap[2];
   assign en.s3 = cap[3];
   assign en.s4 = cap[4];
   assign en.s5 = cap[5];
   assign en.s6 = cap[6];

   always_comb begin
      valid_in[1] = cap[1] ? accept : valid_ff[1];
      for (int k = 2; k <= 6; k++) begin
         valid_in[k] = cap[k] ? valid_ff[k-1] : valid_ff[k];
      end
      rsp_valid_in = cap[7] ? valid_ff[6] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff[1] <= req_idx;
         in_range_ff[1] <= req_in_range;
         exc1_ff <= $signed(req_tdata[41:10]);
         inh1_ff <= $signed(req_tdata[73:42]);
         ext1_ff <= $signed(req_tdata[105:74]);
         off1_ff <= $signed(req_tdata[137:106]);
         force1_ff <= req_tuser;
      end
      for (int k = 2; k <= 6; k++) begin
         if (cap[k]) begin
            idx_ff[k] <= idx_ff[k-1];
            in_range_ff[k] <= in_range_ff[k-1];
         end
      end
      if (cap[7]) begin
         rsp_idx_ff <= idx_ff[6];
         rsp_fired_ff <= in_range_ff[6] && fired;
         rsp_hist_ff <= in_range_ff[6] ? hist_new : '0;
         rsp_volt_ff <= in_range_ff[6] ? v_store : '0;
      end
   end

   assign wr_state = '{
      voltage: v_store,
      exc:     exc_new,
      inh:     inh_new,
      ticks:   ticks_new,
      history: hist_new
   };

   lce_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lce_state_ram u_ram (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (req_idx),
      .rd_data  (rd_state),
      .wr_en    (wb_en),
      .wr_addr  (idx_ff[6]),
      .wr_data  (wr_state),
      .clearing (clearing)
   );

   lce_syn u_syn (
      .clock   (clock),
      .cfg     (cfg),
      .en      (en),
      .exc_old ($signed(rd_state.exc)),
      .inh_old ($signed(rd_state.inh)),
      .exc_in  (exc1_ff),
      .inh_in  (inh1_ff),
      .ext_in  (ext1_ff),
      .off_in  (off1_ff),
      .itot    (itot),
      .exc_new (exc_new),
      .inh_new (inh_new)
   );

   lce_soma u_soma (
      .clock      (clock),
      .cfg        (cfg),
      .en         (en),
      .v_old      ($signed(rd_state.voltage)),
      .ticks_old  (rd_state.ticks),
      .hist_old   (rd_state.history),
      .force_fire (force1_ff),
      .itot       (itot),
      .fired      (fired),
      .v_store    (v_store),
      .ticks_new  (ticks_new),
      .hist_new   (hist_new)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_fired_ff;
   assign rsp_tdata = {6'd0, rsp_volt_ff, rsp_hist_ff, rsp_idx_ff};

   assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && valid_ff[2] |-> idx_ff[1] != idx_ff[2])
      else $error("Two adjacent stages hold the same neuron.");

   assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && valid_ff[6] |-> idx_ff[1] != idx_ff[6])
      else $error("A neuron entered before its previous update was written back.");

endmodule
